/* rtl/core/transformed_bounding_box_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the transformed bounding box
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TRANSFORMED_BOUNDING_BOX_MACROS_SVH
`define TRANSFORMED_BOUNDING_BOX_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbb: implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbb: next-cycle check failed");
`else
`define TBB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TBB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/tbb_pkg.sv */
// ----------------------------------------------------------------------------
// Transformed bounding box package
// Register map, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tbb_pkg;

    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned NUM_REGS   = 6;
    localparam int unsigned REG_W      = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned OUT_W      = 16;
    localparam int unsigned OUT_FIELDS = 12;
    localparam int unsigned OUT_DATA_W = OUT_W * OUT_FIELDS;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW_X_AB = 3'd0,
        REG_ROW_X_CT = 3'd1,
        REG_ROW_Y_AB = 3'd2,
        REG_ROW_Y_CT = 3'd3,
        REG_ROW_Z_AB = 3'd4,
        REG_ROW_Z_CT = 3'd5
    } tbb_reg_t;

    localparam logic [REG_W-1:0] RST_ROW_X_AB = 32'h1000_0000;
    localparam logic [REG_W-1:0] RST_ROW_X_CT = 32'h0000_0000;
    localparam logic [REG_W-1:0] RST_ROW_Y_AB = 32'h0000_1000;
    localparam logic [REG_W-1:0] RST_ROW_Y_CT = 32'h0000_0000;
    localparam logic [REG_W-1:0] RST_ROW_Z_AB = 32'h0000_0000;
    localparam logic [REG_W-1:0] RST_ROW_Z_CT = 32'h1000_0000;

    // One row of the affine transform: out = a*x + b*y + c*z + t
    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] t;
    } tbb_row_t;

endpackage

`default_nettype wire

/* rtl/core/tbb_run_tracker.sv */
// ----------------------------------------------------------------------------
// Running extent tracker
// Keeps per-axis running min/max and hands the box on at the last vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module tbb_run_tracker #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] in_pos [3],
    input  wire logic                          in_last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      out_min [3],
    output logic signed [COORD_WIDTH-1:0]      out_max [3]
);

    localparam logic signed [COORD_WIDTH-1:0] C_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] run_min_reg  [3];
    logic signed [COORD_WIDTH-1:0] run_max_reg  [3];
    logic signed [COORD_WIDTH-1:0] run_min_next [3];
    logic signed [COORD_WIDTH-1:0] run_max_next [3];
    logic signed [COORD_WIDTH-1:0] upd_min      [3];
    logic signed [COORD_WIDTH-1:0] upd_max      [3];
    logic signed [COORD_WIDTH-1:0] box_min_reg  [3];
    logic signed [COORD_WIDTH-1:0] box_max_reg  [3];
    logic                          box_valid_reg;
    logic                          box_valid_next;
    logic                          accept;
    logic                          close_box;

    assign in_ready  = !box_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign close_box = accept && in_last;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            upd_min[i] = (in_pos[i] < run_min_reg[i]) ? in_pos[i] : run_min_reg[i];
            upd_max[i] = (in_pos[i] > run_max_reg[i]) ? in_pos[i] : run_max_reg[i];
            if (close_box)
            begin
                run_min_next[i] = C_HI;
                run_max_next[i] = C_LO;
            end
            else if (accept)
            begin
                run_min_next[i] = upd_min[i];
                run_max_next[i] = upd_max[i];
            end
            else
            begin
                run_min_next[i] = run_min_reg[i];
                run_max_next[i] = run_max_reg[i];
            end
        end
    end

    always_comb
    begin
        if (close_box)
            box_valid_next = 1'b1;
        else if (out_ready)
            box_valid_next = 1'b0;
        else
            box_valid_next = box_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                run_min_reg[i] <= C_HI;
                run_max_reg[i] <= C_LO;
            end
        end
        else
        begin
            box_valid_reg <= box_valid_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
        end
    end

    // Last vertex is part of the box
    always_ff @(posedge clk)
    begin
        if (close_box)
        begin
            box_min_reg <= upd_min;
            box_max_reg <= upd_max;
        end
    end

    assign out_valid = box_valid_reg;
    assign out_min   = box_min_reg;
    assign out_max   = box_max_reg;

endmodule

`default_nettype wire

/* rtl/core/tbb_corner_mul.sv */
// ----------------------------------------------------------------------------
// Corner product stage
// Picks, per coefficient sign, the extreme corner and registers the products.
// ----------------------------------------------------------------------------
`default_nettype none

module tbb_corner_mul #(
    parameter int unsigned COORD_WIDTH = 16,
    parameter int unsigned PROD_W      = COORD_WIDTH + tbb_pkg::COEF_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] box_min [3],
    input  wire logic signed [COORD_WIDTH-1:0] box_max [3],
    input  wire tbb_pkg::tbb_row_t             rows [3],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [PROD_W-1:0]           prod_lo [3][3],
    output logic signed [PROD_W-1:0]           prod_hi [3][3]
);

    localparam int unsigned CW = tbb_pkg::COEF_W;

    logic signed [CW-1:0]          coef      [3][3];
    logic signed [COORD_WIDTH-1:0] sel_lo    [3][3];
    logic signed [COORD_WIDTH-1:0] sel_hi    [3][3];
    logic signed [PROD_W-1:0]      lo_next   [3][3];
    logic signed [PROD_W-1:0]      hi_next   [3][3];
    logic signed [PROD_W-1:0]      lo_reg    [3][3];
    logic signed [PROD_W-1:0]      hi_reg    [3][3];
    logic                          valid_reg;
    logic                          load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // A negative coefficient reaches its minimum at the axis maximum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            coef[i][0] = rows[i].a;
            coef[i][1] = rows[i].b;
            coef[i][2] = rows[i].c;
            for (int j = 0; j < 3; j++)
            begin
                sel_lo[i][j]  = coef[i][j][CW-1] ? box_max[j] : box_min[j];
                sel_hi[i][j]  = coef[i][j][CW-1] ? box_min[j] : box_max[j];
                lo_next[i][j] = {{COORD_WIDTH{coef[i][j][CW-1]}}, coef[i][j]}
                              * {{CW{sel_lo[i][j][COORD_WIDTH-1]}}, sel_lo[i][j]};
                hi_next[i][j] = {{COORD_WIDTH{coef[i][j][CW-1]}}, coef[i][j]}
                              * {{CW{sel_hi[i][j][COORD_WIDTH-1]}}, sel_hi[i][j]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod_lo   = lo_reg;
    assign prod_hi   = hi_reg;

endmodule

`default_nettype wire

/* rtl/core/tbb_round_sat.sv */
// ----------------------------------------------------------------------------
// Sum, round and saturate stage
// Adds products and translation, rounds off the Q4.12 coefficient scale half up, clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module tbb_round_sat #(
    parameter int unsigned COORD_WIDTH    = 16,
    parameter int unsigned COEF_FRAC_BITS = 12,
    parameter int unsigned PROD_W         = COORD_WIDTH + tbb_pkg::COEF_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [PROD_W-1:0]      prod_lo [3][3],
    input  wire logic signed [PROD_W-1:0]      prod_hi [3][3],
    input  wire tbb_pkg::tbb_row_t             rows [3],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      res_lo [3],
    output logic signed [COORD_WIDTH-1:0]      res_hi [3]
);

    localparam int unsigned CW = tbb_pkg::COEF_W;
    localparam int unsigned SW = COORD_WIDTH + COEF_FRAC_BITS + 18;

    localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] S_HI = {{(SW-COORD_WIDTH+1){1'b0}},
                                             {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] S_LO = {{(SW-COORD_WIDTH+1){1'b1}},
                                             {(COORD_WIDTH-1){1'b0}}};

    logic signed [SW-1:0]          t_term  [3];
    logic signed [SW-1:0]          sum_lo  [3];
    logic signed [SW-1:0]          sum_hi  [3];
    logic signed [SW-1:0]          shf_lo  [3];
    logic signed [SW-1:0]          shf_hi  [3];
    logic signed [COORD_WIDTH-1:0] lo_next [3];
    logic signed [COORD_WIDTH-1:0] hi_next [3];
    logic signed [COORD_WIDTH-1:0] lo_reg  [3];
    logic signed [COORD_WIDTH-1:0] hi_reg  [3];
    logic                          valid_reg;
    logic                          load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_term[i] = {{(SW-CW){rows[i].t[CW-1]}}, rows[i].t} <<< COEF_FRAC_BITS;
            sum_lo[i] = {{(SW-PROD_W){prod_lo[i][0][PROD_W-1]}}, prod_lo[i][0]}
                      + {{(SW-PROD_W){prod_lo[i][1][PROD_W-1]}}, prod_lo[i][1]}
                      + {{(SW-PROD_W){prod_lo[i][2][PROD_W-1]}}, prod_lo[i][2]}
                      + t_term[i] + HALF;
            sum_hi[i] = {{(SW-PROD_W){prod_hi[i][0][PROD_W-1]}}, prod_hi[i][0]}
                      + {{(SW-PROD_W){prod_hi[i][1][PROD_W-1]}}, prod_hi[i][1]}
                      + {{(SW-PROD_W){prod_hi[i][2][PROD_W-1]}}, prod_hi[i][2]}
                      + t_term[i] + HALF;
            // Arithmetic shift floors toward minus infinity
            shf_lo[i] = sum_lo[i] >>> COEF_FRAC_BITS;
            shf_hi[i] = sum_hi[i] >>> COEF_FRAC_BITS;

            if (shf_lo[i] > S_HI)
                lo_next[i] = S_HI[COORD_WIDTH-1:0];
            else if (shf_lo[i] < S_LO)
                lo_next[i] = S_LO[COORD_WIDTH-1:0];
            else
                lo_next[i] = shf_lo[i][COORD_WIDTH-1:0];

            if (shf_hi[i] > S_HI)
                hi_next[i] = S_HI[COORD_WIDTH-1:0];
            else if (shf_hi[i] < S_LO)
                hi_next[i] = S_LO[COORD_WIDTH-1:0];
            else
                hi_next[i] = shf_hi[i][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign out_valid = valid_reg;
    assign res_lo    = lo_reg;
    assign res_hi    = hi_reg;

endmodule

`default_nettype wire

/* rtl/core/tbb_result.sv */
// ----------------------------------------------------------------------------
// Result stage
// Forms centre and size, packs the 16-bit fields into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbb_result #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]    res_lo [3],
    input  wire logic signed [COORD_WIDTH-1:0]    res_hi [3],
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tbb_pkg::OUT_DATA_W-1:0]        out_data
);

    localparam int unsigned OW = tbb_pkg::OUT_W;
    localparam int unsigned EW = (COORD_WIDTH + 1 > OW) ? COORD_WIDTH + 1 : OW;

    logic signed [EW-1:0]              lo_e   [3];
    logic signed [EW-1:0]              hi_e   [3];
    logic signed [EW-1:0]              sum_e  [3];
    logic signed [EW-1:0]              mid_e  [3];
    logic signed [EW-1:0]              ext_e  [3];
    logic [tbb_pkg::OUT_DATA_W-1:0]    data_next;
    logic [tbb_pkg::OUT_DATA_W-1:0]    data_reg;
    logic                              valid_reg;
    logic                              load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            lo_e[i]  = {{(EW-COORD_WIDTH){res_lo[i][COORD_WIDTH-1]}}, res_lo[i]};
            hi_e[i]  = {{(EW-COORD_WIDTH){res_hi[i][COORD_WIDTH-1]}}, res_hi[i]};
            sum_e[i] = lo_e[i] + hi_e[i];
            mid_e[i] = sum_e[i] >>> 1;
            ext_e[i] = hi_e[i] - lo_e[i];
            data_next[i*OW +: OW]       = lo_e[i][OW-1:0];
            data_next[(3+i)*OW +: OW]   = hi_e[i][OW-1:0];
            data_next[(6+i)*OW +: OW]   = mid_e[i][OW-1:0];
            data_next[(9+i)*OW +: OW]   = ext_e[i][OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/core/transformed_bounding_box.sv */
// ----------------------------------------------------------------------------
// Transformed bounding box
// Tracks the extent of a vertex stream and emits the affine-transformed box.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid / s_axis_tready  one vertex, tlast = last vertex
//  m_axis    out  m_axis_tvalid / m_axis_tready  one box per object
//  cfg       in   cfg_we                         transform registers, no read-back
//
//  A vertex transfers every cycle while the output side drains; only the last
//  vertex of an object occupies the four-stage result pipe (box register,
//  corner products, sum/round/saturate, output register), which a box passes
//  through in that order after its last vertex. Each stage stalls only when
//  full and the next one holds. Reset clears the running extent, the stage
//  valids and the transform registers; payload registers are not reset.
//
`default_nettype none
`include "transformed_bounding_box_macros.svh"

module transformed_bounding_box #(
    parameter int unsigned COORD_WIDTH    = 16,
    parameter int unsigned COEF_FRAC_BITS = 12
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // configuration
    input  wire logic                                     cfg_we,
    input  wire logic [tbb_pkg::CFG_ADDR_W-1:0]           cfg_addr,
    input  wire logic [tbb_pkg::REG_W-1:0]                cfg_wdata,
    // vertex stream
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // pos_x, pos_y, pos_z (COORD_WIDTH each), zero padding to bytes
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    input  wire logic                                     s_axis_tlast,
    // box stream
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // box_min_x/y/z, box_max_x/y/z, mid_x/y/z, extent_x/y/z, 16 bits each
    output logic [tbb_pkg::OUT_DATA_W-1:0]                m_axis_tdata
);

    localparam int unsigned PROD_W = COORD_WIDTH + tbb_pkg::COEF_W;

    logic [tbb_pkg::REG_W-1:0]     cfg_regs_reg [tbb_pkg::NUM_REGS];
    tbb_pkg::tbb_row_t             rows         [3];

    logic signed [COORD_WIDTH-1:0] pos      [3];
    logic signed [COORD_WIDTH-1:0] box_min  [3];
    logic signed [COORD_WIDTH-1:0] box_max  [3];
    logic signed [PROD_W-1:0]      prod_lo  [3][3];
    logic signed [PROD_W-1:0]      prod_hi  [3][3];
    logic signed [COORD_WIDTH-1:0] res_lo   [3];
    logic signed [COORD_WIDTH-1:0] res_hi   [3];

    logic box_valid;
    logic box_ready;
    logic mul_valid;
    logic mul_ready;
    logic rnd_valid;
    logic rnd_ready;

    // ------------------------------------------------------------------
    // Transform registers; writes to unused indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg[tbb_pkg::REG_ROW_X_AB] <= tbb_pkg::RST_ROW_X_AB;
            cfg_regs_reg[tbb_pkg::REG_ROW_X_CT] <= tbb_pkg::RST_ROW_X_CT;
            cfg_regs_reg[tbb_pkg::REG_ROW_Y_AB] <= tbb_pkg::RST_ROW_Y_AB;
            cfg_regs_reg[tbb_pkg::REG_ROW_Y_CT] <= tbb_pkg::RST_ROW_Y_CT;
            cfg_regs_reg[tbb_pkg::REG_ROW_Z_AB] <= tbb_pkg::RST_ROW_Z_AB;
            cfg_regs_reg[tbb_pkg::REG_ROW_Z_CT] <= tbb_pkg::RST_ROW_Z_CT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tbb_pkg::REG_ROW_X_AB: cfg_regs_reg[tbb_pkg::REG_ROW_X_AB] <= cfg_wdata;
                tbb_pkg::REG_ROW_X_CT: cfg_regs_reg[tbb_pkg::REG_ROW_X_CT] <= cfg_wdata;
                tbb_pkg::REG_ROW_Y_AB: cfg_regs_reg[tbb_pkg::REG_ROW_Y_AB] <= cfg_wdata;
                tbb_pkg::REG_ROW_Y_CT: cfg_regs_reg[tbb_pkg::REG_ROW_Y_CT] <= cfg_wdata;
                tbb_pkg::REG_ROW_Z_AB: cfg_regs_reg[tbb_pkg::REG_ROW_Z_AB] <= cfg_wdata;
                tbb_pkg::REG_ROW_Z_CT: cfg_regs_reg[tbb_pkg::REG_ROW_Z_CT] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Split each row pair into coefficients a, b, c and translation t (low half of the second)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rows[i].a = cfg_regs_reg[2*i][31:16];
            rows[i].b = cfg_regs_reg[2*i][15:0];
            rows[i].c = cfg_regs_reg[2*i+1][31:16];
            rows[i].t = cfg_regs_reg[2*i+1][15:0];
        end
    end

    // Unpack the vertex; padding bits above the three fields are ignored
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pos[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end

    // ------------------------------------------------------------------
    // Stage 1: running extent, box captured on the last vertex
    // ------------------------------------------------------------------
    tbb_run_tracker #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pos    (pos),
        .in_last   (s_axis_tlast),
        .out_valid (box_valid),
        .out_ready (box_ready),
        .out_min   (box_min),
        .out_max   (box_max)
    );

    // ------------------------------------------------------------------
    // Stage 2: the transform is linear, so each row's extreme corner is
    // chosen term by term from the coefficient signs; rounding and
    // saturation are monotone and keep that corner extreme.
    // ------------------------------------------------------------------
    tbb_corner_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .PROD_W      (PROD_W)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box_valid),
        .in_ready  (box_ready),
        .box_min   (box_min),
        .box_max   (box_max),
        .rows      (rows),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .prod_lo   (prod_lo),
        .prod_hi   (prod_hi)
    );

    // ------------------------------------------------------------------
    // Stage 3: sum, round half up, saturate to the coordinate range
    // ------------------------------------------------------------------
    tbb_round_sat #(
        .COORD_WIDTH    (COORD_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .PROD_W         (PROD_W)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .prod_lo   (prod_lo),
        .prod_hi   (prod_hi),
        .rows      (rows),
        .out_valid (rnd_valid),
        .out_ready (rnd_ready),
        .res_lo    (res_lo),
        .res_hi    (res_hi)
    );

    // ------------------------------------------------------------------
    // Stage 4: centre, size and output register
    // ------------------------------------------------------------------
    tbb_result #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rnd_valid),
        .in_ready  (rnd_ready),
        .res_lo    (res_lo),
        .res_hi    (res_hi),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // The vertex side only stalls behind a held box
    `TBB_ASSERT_IMP(a_stall_needs_box, clk, rst_n, !s_axis_tready, box_valid)
    // A captured box always contains its last vertex, so it is never inverted
    `TBB_ASSERT_IMP(a_box_ordered, clk, rst_n, box_valid, (box_min[0] <= box_max[0]) && (box_min[1] <= box_max[1]) && (box_min[2] <= box_max[2]))
    // Transformed extremes keep their order through rounding and clamping
    `TBB_ASSERT_IMP(a_rounded_ordered, clk, rst_n, rnd_valid, (res_lo[0] <= res_hi[0]) && (res_lo[1] <= res_hi[1]) && (res_lo[2] <= res_hi[2]))
    // Products only appear after a box was held
    `TBB_ASSERT_IMP(a_mul_from_box, clk, rst_n, $rose(mul_valid), $past(box_valid))

endmodule

`default_nettype wire
